// File: rtl/core/pli_pkg.sv
// Package for the positional list engine: operation and status codes,
// shared widths, and the structs that run along the row of list cells.
// No dependencies.
package pli_pkg;

    // Fixed widths of the item fields.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;

    // Widest position or count needed inside the row (up to 1024 entries).
    localparam int CNT_MAX_W = 11;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_VISIT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic                 ins_en;
        logic                 rem_en;
        logic                 search;
        logic [CNT_MAX_W-1:0] pos;
        logic [CNT_MAX_W-1:0] count;
    } t_cell_ctl;

    // Scan token passed from one cell to the next.
    typedef struct packed {
        logic                 valid;
        logic                 done;
        logic [CNT_MAX_W-1:0] found;
    } t_tok;

endpackage

// File: rtl/core/pli_cell.sv
// One cell of the list row: holds one entry, shifts with its neighbors on
// insert and remove, and checks the passing scan token for search and visit.
// Depends on pli_pkg.
module pli_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pli_pkg::t_cell_ctl     i_ctl,
    input  logic [DATA_WIDTH-1:0]  i_key,
    input  logic [DATA_WIDTH-1:0]  i_prev_data,
    input  logic [DATA_WIDTH-1:0]  i_next_data,
    output logic [DATA_WIDTH-1:0]  o_data,
    input  pli_pkg::t_tok          i_tok,
    input  logic [DATA_WIDTH-1:0]  i_tok_data,
    output pli_pkg::t_tok          o_tok,
    output logic [DATA_WIDTH-1:0]  o_tok_data
);

    localparam logic [pli_pkg::CNT_MAX_W-1:0] IDX = pli_pkg::CNT_MAX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    pli_pkg::t_tok         r_tok;
    pli_pkg::t_tok         n_tok;
    logic [DATA_WIDTH-1:0] r_tok_data;
    logic [DATA_WIDTH-1:0] n_tok_data;
    logic                  hit;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins_en && (IDX > i_ctl.pos)) begin
            n_data = i_prev_data;
        end else if (i_ctl.ins_en && (IDX == i_ctl.pos)) begin
            n_data = i_key;
        end else if (i_ctl.rem_en && (IDX >= i_ctl.pos)) begin
            n_data = i_next_data;
        end
    end

    // The first live cell that matches claims the token; later cells pass it on.
    always_comb begin
        if (i_ctl.search) begin
            hit = i_tok.valid && !i_tok.done && (IDX < i_ctl.count) && (r_data == i_key);
        end else begin
            hit = i_tok.valid && !i_tok.done && (IDX == i_ctl.pos);
        end
        n_tok       = i_tok;
        n_tok_data  = i_tok_data;
        if (hit) begin
            n_tok.done  = 1'b1;
            n_tok.found = IDX;
            n_tok_data  = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_tok_data <= n_tok_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_data     = r_data;
    assign o_tok      = r_tok;
    assign o_tok_data = r_tok_data;

endmodule

// File: rtl/core/positional_list_engine.sv
// Top level of the positional list engine: handshakes, entry count and the
// row of pli_cell instances that holds the list. Depends on pli_pkg, pli_cell.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-------------------------------------
//   request  | i_in_valid   | o_in_ready   | i_kind, i_position, i_value
//   result   | o_out_valid  | i_out_ready  | o_status, o_found_position,
//            |              |              | o_read_value, o_count
//
// Insert, remove, clear, unknown kinds and rejected requests finish at the
// transfer edge, so the result is offered in the next cycle. Search and an
// in-range visit send a token down the whole row, one cell per cycle; the
// token leaving the last cell gives the result. One request is in work at a
// time. A stalled result is held; a new request is taken once the output
// register is free or being drained. Reset clears the count and handshakes.
module positional_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pli_pkg::KIND_W-1:0]    i_kind,
    input  logic [pli_pkg::POS_W-1:0]     i_position,
    input  logic [pli_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pli_pkg::STATUS_W-1:0]  o_status,
    output logic [pli_pkg::FOUND_W-1:0]   o_found_position,
    output logic [pli_pkg::VALUE_W-1:0]   o_read_value,
    output logic [pli_pkg::COUNT_W-1:0]   o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (DATA_WIDTH > pli_pkg::VALUE_W) ? DATA_WIDTH : pli_pkg::VALUE_W;
    localparam int CMW   = pli_pkg::CNT_MAX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Request fields kept for the length of a scan.
    logic                  r_search;
    logic [CMW-1:0]        r_pos;
    logic [DATA_WIDTH-1:0] r_key;

    logic                             r_out_vld;
    logic                             n_out_vld;
    logic [pli_pkg::STATUS_W-1:0]     r_out_status;
    logic [pli_pkg::FOUND_W-1:0]      r_out_found;
    logic [pli_pkg::VALUE_W-1:0]      r_out_read;
    logic [pli_pkg::COUNT_W-1:0]      r_out_count;

    logic [pli_pkg::STATUS_W-1:0]     r_hold_status;
    logic [pli_pkg::FOUND_W-1:0]      r_hold_found;
    logic [pli_pkg::VALUE_W-1:0]      r_hold_read;

    logic                  out_free;
    logic                  acc;
    logic [EXT_W-1:0]      val_ext;
    logic [DATA_WIDTH-1:0] in_key;
    logic [CMW-1:0]        pos_ext;
    logic [CMW-1:0]        cnt_ext;
    logic [CMW-1:0]        n_cnt_ext;
    logic                  full;

    logic                         imm_done;
    logic                         scan_start;
    logic                         ins_en;
    logic                         rem_en;
    logic [pli_pkg::STATUS_W-1:0] imm_status;

    logic                         tok_end;
    logic [pli_pkg::STATUS_W-1:0] scan_status;
    logic [pli_pkg::FOUND_W-1:0]  scan_found;
    logic [pli_pkg::VALUE_W-1:0]  scan_read;
    logic [EXT_W-1:0]             rd_ext;

    pli_pkg::t_cell_ctl    ctl;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    pli_pkg::t_tok         tok_c     [CAPACITY+1];
    logic [DATA_WIDTH-1:0] tok_d     [CAPACITY+1];

    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign acc        = i_in_valid && o_in_ready;

    assign val_ext   = EXT_W'(i_value);
    assign in_key    = val_ext[DATA_WIDTH-1:0];
    assign pos_ext   = CMW'(i_position);
    assign cnt_ext   = CMW'(r_count);
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign n_cnt_ext = CMW'(n_count);

    // Decode the request at the transfer edge.
    always_comb begin
        imm_done   = 1'b1;
        scan_start = 1'b0;
        ins_en     = 1'b0;
        rem_en     = 1'b0;
        imm_status = pli_pkg::STAT_OK;
        n_count    = r_count;
        unique case (i_kind)
            pli_pkg::KIND_INSERT: begin
                if (full) begin
                    imm_status = pli_pkg::STAT_FULL;
                end else if (pos_ext > cnt_ext) begin
                    imm_status = pli_pkg::STAT_RANGE;
                end else begin
                    ins_en  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            pli_pkg::KIND_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    imm_status = pli_pkg::STAT_RANGE;
                end else begin
                    rem_en  = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            pli_pkg::KIND_SEARCH: begin
                imm_done   = 1'b0;
                scan_start = 1'b1;
            end
            pli_pkg::KIND_VISIT: begin
                if (pos_ext >= cnt_ext) begin
                    imm_status = pli_pkg::STAT_RANGE;
                end else begin
                    imm_done   = 1'b0;
                    scan_start = 1'b1;
                end
            end
            pli_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // During the transfer cycle the row sees the incoming request directly.
    always_comb begin
        ctl.ins_en = acc && ins_en;
        ctl.rem_en = acc && rem_en;
        ctl.search = acc ? (i_kind == pli_pkg::KIND_SEARCH) : r_search;
        ctl.pos    = acc ? pos_ext : r_pos;
        ctl.count  = cnt_ext;
        key        = acc ? in_key : r_key;
    end

    assign tok_c[0].valid = acc && scan_start;
    assign tok_c[0].done  = 1'b0;
    assign tok_c[0].found = '0;
    assign tok_d[0]       = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        logic [DATA_WIDTH-1:0] next_data;

        if (g == 0) begin : g_first
            assign prev_data = key;
        end else begin : g_mid_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid_next
            assign next_data = cell_data[g+1];
        end

        pli_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_key       (key),
            .i_prev_data (prev_data),
            .i_next_data (next_data),
            .o_data      (cell_data[g]),
            .i_tok       (tok_c[g]),
            .i_tok_data  (tok_d[g]),
            .o_tok       (tok_c[g+1]),
            .o_tok_data  (tok_d[g+1])
        );
    end

    // Token leaving the last cell carries the scan outcome.
    assign tok_end = tok_c[CAPACITY].valid;
    assign rd_ext  = EXT_W'(tok_d[CAPACITY]);

    always_comb begin
        scan_status = pli_pkg::STAT_OK;
        scan_found  = '0;
        scan_read   = '0;
        if (r_search) begin
            if (tok_c[CAPACITY].done) begin
                scan_found = tok_c[CAPACITY].found[pli_pkg::FOUND_W-1:0];
            end else begin
                scan_status = pli_pkg::STAT_NOTFOUND;
            end
        end else begin
            scan_read = rd_ext[pli_pkg::VALUE_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && imm_done) begin
                    n_out_vld = 1'b1;
                end else if (acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_end && out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end else if (tok_end) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (acc) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_search <= (i_kind == pli_pkg::KIND_SEARCH);
            r_pos    <= pos_ext;
            r_key    <= in_key;
        end
        if ((r_state == ST_SCAN) && tok_end) begin
            r_hold_status <= scan_status;
            r_hold_found  <= scan_found;
            r_hold_read   <= scan_read;
        end
        if ((r_state == ST_IDLE) && acc && imm_done) begin
            r_out_status <= imm_status;
            r_out_found  <= '0;
            r_out_read   <= '0;
            r_out_count  <= n_cnt_ext[pli_pkg::COUNT_W-1:0];
        end else if ((r_state == ST_SCAN) && tok_end && out_free) begin
            r_out_status <= scan_status;
            r_out_found  <= scan_found;
            r_out_read   <= scan_read;
            r_out_count  <= cnt_ext[pli_pkg::COUNT_W-1:0];
        end else if ((r_state == ST_HOLD) && out_free) begin
            r_out_status <= r_hold_status;
            r_out_found  <= r_hold_found;
            r_out_read   <= r_hold_read;
            r_out_count  <= cnt_ext[pli_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_read_value     = r_out_read;
    assign o_count          = r_out_count;

endmodule
